// ----- hw/rtl/rmsod_pkg.sv -----
// ----------------------------------------------------------------------------
// rmsod_pkg
// shared constants and types of the rms energy onset detector
// ----------------------------------------------------------------------------
package rmsod_pkg;

	localparam int FRAME_SAMPLES = 256;
	localparam int MAX_ONSETS    = 16;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int FILL_W   = $clog2(FRAME_SAMPLES + 1);
	// a square is at most 2^30, so a frame sum stays below 2^(30+FILL_W)
	localparam int SUM_W    = 30 + FILL_W;
	localparam int QUO_W    = 31;
	localparam int RMS_W    = 16;
	localparam int POS_W    = 24;
	localparam int CNT_W    = 7;
	localparam int THR_W    = 16;
	localparam int DIV_CNT_W  = $clog2(SUM_W);
	localparam int ROOT_IDX_W = $clog2(RMS_W);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONSET_GAP      = 1'd1;

	localparam logic [THR_W-1:0] RISE_THRESHOLD_RST = 16'd3277;
	localparam logic [POS_W-1:0] ONSET_GAP_RST      = 24'd2400;

	// result kinds
	localparam logic KIND_ONSET = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef struct packed {
		logic [THR_W-1:0] rise_threshold;
		logic [POS_W-1:0] onset_gap;
	} rmsod_cfg_t;

	// one job from the front to the back
	typedef struct packed {
		logic             first;   // first sample of a clip: onset at 0
		logic             eval;    // a frame is complete
		logic             last;    // clip ends with this frame
		logic [SUM_W-1:0]  sum;
		logic [FILL_W-1:0] fill;
		logic [POS_W-1:0]  start;
	} rmsod_job_t;

endpackage

// ----- hw/rtl/rmsod_front.sv -----
// ----------------------------------------------------------------------------
// rmsod_front
// takes samples, accumulates frame energy and posts frame jobs
// ----------------------------------------------------------------------------
module rmsod_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rmsod_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                          in_last,
	input  logic                          q_full,
	output logic                          q_push,
	output rmsod_pkg::rmsod_job_t         q_job
);
	import rmsod_pkg::*;

	logic [SUM_W-1:0]  sum_q;
	logic [FILL_W-1:0] fill_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  start_q;

	logic              accept;
	logic              first;
	logic              frame_end;
	logic [MAG_W-1:0]  mag;
	logic [SQ_W-1:0]   sq;
	logic [SUM_W-1:0]  sum_new;
	logic [FILL_W-1:0] fill_new;
	logic [POS_W-1:0]  start_now;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mag       = in_sample[SAMPLE_W-1] ? MAG_W'(~in_sample + 1'b1) : MAG_W'(in_sample);
		sq        = mag * mag;
		sum_new   = sum_q + SUM_W'(sq);
		fill_new  = fill_q + 1'b1;
		first     = (pos_q == '0) && (fill_q == '0);
		start_now = (fill_q == '0) ? pos_q : start_q;
		frame_end = (fill_new == FILL_W'(FRAME_SAMPLES)) || in_last;
	end

	assign q_push      = accept && (first || frame_end);
	assign q_job.first = first;
	assign q_job.eval  = frame_end;
	assign q_job.last  = in_last;
	assign q_job.sum   = sum_new;
	assign q_job.fill  = fill_new;
	assign q_job.start = start_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			fill_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
		end else if (accept) begin
			start_q <= start_now;
			if (in_last) begin
				sum_q  <= '0;
				fill_q <= '0;
				pos_q  <= '0;
			end else begin
				if (frame_end) begin
					sum_q  <= '0;
					fill_q <= '0;
				end else begin
					sum_q  <= sum_new;
					fill_q <= fill_new;
				end
				// position saturates at its top value
				if (pos_q != POS_MAX) pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/rmsod_queue.sv -----
// ----------------------------------------------------------------------------
// rmsod_queue
// two-entry job queue between the front and the back
// ----------------------------------------------------------------------------
module rmsod_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rmsod_pkg::rmsod_job_t push_job,
	output logic                  full,
	input  logic                  pop,
	output logic                  avail,
	output rmsod_pkg::rmsod_job_t pop_job
);
	import rmsod_pkg::*;

	rmsod_job_t  entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full    = (count_q == 2'd2);
	assign avail   = (count_q != 2'd0);
	assign pop_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/rmsod_back.sv -----
// ----------------------------------------------------------------------------
// rmsod_back
// per-frame mean, square root, onset decision and result register
// ----------------------------------------------------------------------------
module rmsod_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rmsod_pkg::rmsod_cfg_t cfg,
	input  logic                  q_avail,
	input  rmsod_pkg::rmsod_job_t q_job,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,
	output logic                  m_tuser
);
	import rmsod_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_ROOT  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_ONSET = 3'd5;
	localparam logic [2:0] ST_END   = 3'd6;

	logic [2:0]            state_q;
	rmsod_job_t            job_q;
	logic [SUM_W-1:0]      div_num_q;
	logic [FILL_W-1:0]     div_rem_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [RMS_W-1:0]      root_q;
	logic [ROOT_IDX_W-1:0] root_idx_q;
	logic [RMS_W-1:0]      rms_last_q;
	logic [POS_W-1:0]      last_onset_q;
	logic [CNT_W-1:0]      count_q;
	logic                  closed_q;

	logic                  m_valid_q;
	logic                  m_kind_q;
	logic [POS_W-1:0]      m_pos_q;
	logic [CNT_W-1:0]      m_total_q;

	logic                  slot_free;
	logic                  emit;
	logic                  e_kind;
	logic [POS_W-1:0]      e_pos;
	logic [CNT_W-1:0]      e_total;

	logic [FILL_W:0]       div_trial;
	logic                  div_ge;
	logic [FILL_W-1:0]     div_rem_next;
	logic [RMS_W-1:0]      root_trial;
	logic [2*RMS_W-1:0]    root_sq;
	logic [RMS_W-1:0]      rise;
	logic                  fire;
	logic                  at_limit;

	assign slot_free = !m_valid_q || m_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tuser   = m_kind_q;
	assign m_tdata   = {1'b0, m_total_q, m_pos_q};

	// one quotient bit a cycle
	always_comb begin
		div_trial    = {div_rem_q, div_num_q[SUM_W-1]};
		div_ge       = div_trial >= {1'b0, job_q.fill};
		div_rem_next = div_ge ? FILL_W'(div_trial - {1'b0, job_q.fill}) : FILL_W'(div_trial);
	end

	// one root bit a cycle, quotient held in the low bits of div_num_q
	always_comb begin
		root_trial             = root_q;
		root_trial[root_idx_q] = 1'b1;
		root_sq                = root_trial * root_trial;
	end

	always_comb begin
		rise     = (root_q > rms_last_q) ? root_q - rms_last_q : '0;
		fire     = (job_q.start != '0) && (job_q.start != POS_MAX)
		        && (rise > cfg.rise_threshold)
		        && ((job_q.start - last_onset_q) >= cfg.onset_gap);
		at_limit = count_q >= CNT_W'(MAX_ONSETS);
	end

	always_comb begin
		emit    = 1'b0;
		e_kind  = KIND_ONSET;
		e_pos   = '0;
		e_total = count_q;
		unique case (state_q)
			ST_FIRST: begin
				emit    = 1'b1;
				e_total = CNT_W'(1);
			end
			ST_ONSET: begin
				emit  = 1'b1;
				e_pos = job_q.start;
			end
			ST_END: begin
				emit   = 1'b1;
				e_kind = KIND_END;
			end
			default: emit = 1'b0;
		endcase
	end

	assign q_pop = (state_q == ST_IDLE) && q_avail;

	always_ff @(posedge clk) begin
		if (slot_free && emit) begin
			m_kind_q  <= e_kind;
			m_pos_q   <= e_pos;
			m_total_q <= e_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (slot_free) begin
			m_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					job_q      <= q_job;
					div_num_q  <= q_job.sum;
					div_rem_q  <= '0;
					div_cnt_q  <= DIV_CNT_W'(SUM_W - 1);
				end
			end
			ST_DIV: begin
				div_num_q <= {div_num_q[SUM_W-2:0], div_ge};
				div_rem_q <= div_rem_next;
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == '0) begin
					root_q     <= '0;
					root_idx_q <= ROOT_IDX_W'(RMS_W - 1);
				end
			end
			ST_ROOT: begin
				if (root_sq <= (2*RMS_W)'(div_num_q[QUO_W-1:0])) root_q <= root_trial;
				root_idx_q <= root_idx_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rms_last_q   <= '0;
			last_onset_q <= '0;
			count_q      <= '0;
			closed_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (closed_q) begin
							// list full: drop jobs until the clip ends
							if (q_job.last) begin
								closed_q     <= 1'b0;
								count_q      <= '0;
								rms_last_q   <= '0;
								last_onset_q <= '0;
							end
						end else begin
							state_q <= q_job.first ? ST_FIRST : ST_DIV;
						end
					end
				end
				ST_FIRST: begin
					if (slot_free) begin
						count_q <= CNT_W'(1);
						state_q <= job_q.eval ? ST_DIV : ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_idx_q == '0) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					rms_last_q <= root_q;
					if (fire) begin
						count_q      <= count_q + 1'b1;
						last_onset_q <= job_q.start;
						state_q      <= ST_ONSET;
					end else begin
						state_q <= job_q.last ? ST_END : ST_IDLE;
					end
				end
				ST_ONSET: begin
					if (slot_free) begin
						if (at_limit) begin
							closed_q <= 1'b1;
							state_q  <= ST_END;
						end else begin
							state_q <= job_q.last ? ST_END : ST_IDLE;
						end
					end
				end
				ST_END: begin
					if (slot_free) begin
						if (job_q.last) begin
							closed_q     <= 1'b0;
							count_q      <= '0;
							rms_last_q   <= '0;
							last_onset_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/rms_energy_onset_detector.sv -----
// ----------------------------------------------------------------------------
// rms_energy_onset_detector
// energy-based onset detection over a streamed audio clip
// ----------------------------------------------------------------------------
// usage: samples (signed q1.15) enter on the s_ channel, s_tlast on a clip's
// final sample. results leave on the m_ channel: m_tuser 0 is an onset at
// m_tdata[23:0] with the running total in m_tdata[30:24], m_tuser 1 closes
// the onset list. the first sample always yields an onset at position 0.
// the cfg channel writes rise_threshold (index 0) and the minimum onset
// spacing in samples (index 1); cfg_ready is always high, and writes belong
// between clips.
// throughput: one sample per cycle into the front accumulator. the back end
// then works through each frame: one quotient bit per cycle in the divider,
// then one root bit per cycle. a two-job queue lets the front keep
// accumulating meanwhile; the front stalls only when both queue entries are
// taken. a job is registered in the queue and in the back end, and its
// result in the result register before it leaves.
// reset: all clip state cleared, registers back to 3277 and 2400.
// when the receiver stalls, the result register holds, the back end waits,
// and the queue then fills and stalls the input.
// ----------------------------------------------------------------------------
module rms_energy_onset_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,   // [15:0] sample_value
	input  logic                             s_tlast,   // last_sample
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,   // [23:0] onset_position, [30:24] onset_total
	output logic                             m_tuser,   // [0] result_kind
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rmsod_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rmsod_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rmsod_pkg::*;

	rmsod_cfg_t cfg_q;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_avail;
	rmsod_job_t push_job;
	rmsod_job_t pop_job;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_threshold <= RISE_THRESHOLD_RST;
			cfg_q.onset_gap      <= ONSET_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RISE_THRESHOLD: cfg_q.rise_threshold <= cfg_data[THR_W-1:0];
				REG_ONSET_GAP:      cfg_q.onset_gap      <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// front: squares and sums samples, posts a job per frame or clip start
	rmsod_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata[SAMPLE_W-1:0]),
		.in_last   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	// decouples sample intake from the per-frame arithmetic
	rmsod_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.pop_job  (pop_job)
	);

	// back: mean square, root, onset rules, result register
	rmsod_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_avail  (q_avail),
		.q_job    (pop_job),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- hw/rtl/rmsod_checker.sv -----
// ----------------------------------------------------------------------------
// rmsod_checker
// port-level checks of the onset detector, bound to the top level
// ----------------------------------------------------------------------------
module rmsod_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser
);
	import rmsod_pkg::*;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// an end result carries no position
	a_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_END) |-> (m_tdata[23:0] == 24'd0))
		else $error("end result with nonzero position");

	// an onset total is never zero and never above the limit
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_ONSET)
		|-> (m_tdata[30:24] != 7'd0) && (m_tdata[30:24] <= CNT_W'(MAX_ONSETS)))
		else $error("onset total out of range");

	// the pad bit of the result stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[31])
		else $error("result pad bit set");

endmodule

bind rms_energy_onset_detector rmsod_checker u_checker (.*);
